FILE: rtl/mspid_pkg.sv
// Shared types and constants for the motor speed PID block.
`default_nettype none

package mspid_pkg;

   localparam int FRAC_BITS_DEF = 16;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // serial multiplier geometry
   localparam int MCAND_W  = 33;
   localparam int MPLIER_W = 32;
   localparam int PROD_W   = MCAND_W + MPLIER_W;
   localparam int DIGIT_W  = 4;

   // divider quotient window; anything above it only sets the sticky flag
   localparam int QUOT_W = 17;
   localparam int DVS_W  = 17;

   typedef enum logic [2:0] {
      REG_GAIN_PROP      = 3'd0,
      REG_GAIN_INTEGRAL  = 3'd1,
      REG_GAIN_DERIV     = 3'd2,
      REG_GAIN_SPEED_FB  = 3'd3,
      REG_PULSE_TO_SPEED = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] prop;
      logic signed [31:0] integral;
      logic signed [31:0] deriv;
      logic signed [31:0] speed_fb;
      logic [31:0]        pulse_to_speed;
   } gains_type;

   typedef struct packed {
      logic              done;
      logic              big;
      logic [QUOT_W-1:0] quot;
   } div_result_type;

endpackage

`default_nettype wire

FILE: rtl/mspid_csr.sv
// Configuration registers with an APB-style write and read port.
`default_nettype none

module mspid_csr import mspid_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output gains_type             gains
);

   // gains at zero, pulse scale at 1.0
   localparam gains_type GAINS_RST = '{
      prop:           '0,
      integral:       '0,
      deriv:          '0,
      speed_fb:       '0,
      pulse_to_speed: 32'd1 << FRAC_BITS
   };

   gains_type     gains_ff, gains_in;
   reg_index_type index;
   logic          wr_en;

   assign index  = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign gains  = gains_ff;

   always_comb begin
      gains_in = gains_ff;
      if (wr_en) begin
         case (index)
            REG_GAIN_PROP:      gains_in.prop           = pwdata;
            REG_GAIN_INTEGRAL:  gains_in.integral       = pwdata;
            REG_GAIN_DERIV:     gains_in.deriv          = pwdata;
            REG_GAIN_SPEED_FB:  gains_in.speed_fb       = pwdata;
            REG_PULSE_TO_SPEED: gains_in.pulse_to_speed = pwdata;
            default:            gains_in                = gains_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_GAIN_PROP:      prdata = gains_ff.prop;
         REG_GAIN_INTEGRAL:  prdata = gains_ff.integral;
         REG_GAIN_DERIV:     prdata = gains_ff.deriv;
         REG_GAIN_SPEED_FB:  prdata = gains_ff.speed_fb;
         REG_PULSE_TO_SPEED: prdata = gains_ff.pulse_to_speed;
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff <= GAINS_RST;
      end else begin
         gains_ff <= gains_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/mspid_mul.sv
// Digit-serial signed multiplier, one four-bit multiplier digit per cycle.
`default_nettype none

module mspid_mul import mspid_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [MCAND_W-1:0] mcand,
   input  logic signed [MPLIER_W-1:0] mplier,
   output logic                      done,
   output logic signed [PROD_W-1:0]  product
);

   localparam int DIGITS = MPLIER_W / DIGIT_W;
   localparam int CNT_W  = $clog2(DIGITS);
   localparam int ACC_W  = MCAND_W + DIGIT_W + 1;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [MCAND_W-1:0] mcand_ff, mcand_in;
   logic [MPLIER_W-1:0]       mpl_ff, mpl_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [MPLIER_W-1:0]       lo_ff, lo_in;

   logic                      last;
   logic signed [DIGIT_W:0]   dig_s;
   logic signed [ACC_W-1:0]   partial;
   logic signed [ACC_W:0]     sum;

   assign last = (cnt_ff == CNT_W'(DIGITS - 1));

   always_comb begin
      // top digit carries the multiplier's sign
      if (last) dig_s = {mpl_ff[DIGIT_W-1], mpl_ff[DIGIT_W-1:0]};
      else      dig_s = {1'b0, mpl_ff[DIGIT_W-1:0]};
      partial = ACC_W'(mcand_ff) * ACC_W'(dig_s);
      sum     = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(partial);
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      mpl_in   = mpl_ff;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = mcand;
         mpl_in   = mplier;
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in = ACC_W'(sum >>> DIGIT_W);
         lo_in  = {sum[DIGIT_W-1:0], lo_ff[MPLIER_W-1:DIGIT_W]};
         mpl_in = mpl_ff >> DIGIT_W;
         cnt_in = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      mpl_ff   <= mpl_in;
      acc_ff   <= acc_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {acc_ff[MCAND_W-1:0], lo_ff};

endmodule

`default_nettype wire

FILE: rtl/mspid_div.sv
// Restoring divider, two quotient bits per cycle, with a sticky overflow flag.
`default_nettype none

module mspid_div import mspid_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [2*((65-FRAC_BITS)/2)-1:0] num,
   input  logic [DVS_W-1:0]               divisor,
   output div_result_type                 result
);

   localparam int DIV_STEPS = (65 - FRAC_BITS) / 2;
   localparam int NUM_W     = 2 * DIV_STEPS;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic              big_ff, big_in;

   logic              last;
   logic [DVS_W:0]    t1, t2;
   logic [DVS_W+1:0]  d1, d2;
   logic              b1, b2;
   logic [DVS_W-1:0]  r1, r2;

   assign last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   always_comb begin
      t1 = {rem_ff, num_ff[NUM_W-1]};
      d1 = {1'b0, t1} - (DVS_W+2)'(dvs_ff);
      b1 = ~d1[DVS_W+1];
      r1 = b1 ? d1[DVS_W-1:0] : t1[DVS_W-1:0];
      t2 = {r1, num_ff[NUM_W-2]};
      d2 = {1'b0, t2} - (DVS_W+2)'(dvs_ff);
      b2 = ~d2[DVS_W+1];
      r2 = b2 ? d2[DVS_W-1:0] : t2[DVS_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      big_in  = big_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         dvs_in  = divisor;
         rem_in  = '0;
         quot_in = '0;
         big_in  = 1'b0;
      end else if (busy_ff) begin
         num_in  = num_ff << 2;
         rem_in  = r2;
         quot_in = {quot_ff[QUOT_W-3:0], b1, b2};
         big_in  = big_ff | quot_ff[QUOT_W-1] | quot_ff[QUOT_W-2];
         cnt_in  = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      big_ff  <= big_in;
   end

   assign result.done = done_ff;
   assign result.big  = big_ff;
   assign result.quot = quot_ff;

endmodule

`default_nettype wire

FILE: rtl/motor_speed_pid_with_supply_comp.sv
// Top level: motor speed PID with clamped integral and supply compensation.
//
// Usage: one request item per control tick carries target speed, encoder
// pulse count and battery voltage. One response item comes back with duty,
// measured speed and two limit flags. Gains and pulse scale sit in APB
// registers at 0x00..0x10; write them only while the block is idle.
// Timing: one item at a time. The time from accept to response valid is
// set by the shared digit-serial multiplier (four-bit digits, five
// products in a row) and the divider that retires two quotient bits a
// cycle. req_stall falls in the same cycle that rsp_valid rises.
// req_stall is high from accept until the result is parked in the output
// register; a new item is taken while that result waits. If the receiver
// still stalls the old result, the next one holds in the last step.
// Reset (synchronous) clears the integral and previous error, loads the
// gains with zero and the pulse scale with 1.0, and drops rsp_valid.
`default_nettype none

module motor_speed_pid_with_supply_comp import mspid_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic signed [31:0]    req_target_speed,
   input  logic signed [15:0]    req_pulse_count,
   input  logic [15:0]           req_battery_volts,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [15:0]    rsp_duty,
   output logic signed [31:0]    rsp_measured_speed,
   output logic                  rsp_integral_limited,
   output logic                  rsp_duty_limited,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int NUM_W = 2 * ((65 - FRAC_BITS) / 2);
   localparam int U_W   = 66 - FRAC_BITS;   // holds the sum of four scaled products

   // integral bound: 150.0, or the largest 32-bit value when it does not fit
   localparam longint LIM_RAW = longint'(150) << FRAC_BITS;
   localparam longint LIM_V   = (LIM_RAW > 64'sd2147483647) ? 64'sd2147483647 : LIM_RAW;
   localparam logic signed [32:0] LIM = 33'(LIM_V);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_MUL    = 9'b000000010,
      ST_SPEED  = 9'b000000100,
      ST_ERROR  = 9'b000001000,
      ST_INTEG  = 9'b000010000,
      ST_ACCUM  = 9'b000100000,
      ST_SETUP  = 9'b001000000,
      ST_DIVIDE = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   typedef enum logic [2:0] {
      OP_SPEED = 3'd0,
      OP_PROP  = 3'd1,
      OP_INTEG = 3'd2,
      OP_DERIV = 3'd3,
      OP_FEED  = 3'd4
   } op_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x[65:31] == '0 || x[65:31] == '1) r = x[31:0];
      else if (x[65])                       r = 32'sh80000000;
      else                                  r = 32'sh7fffffff;
      return r;
   endfunction

   gains_type gains;

   state_type                 state_ff, state_in;
   op_type                    op_ff, op_in;
   logic signed [31:0]        target_ff, target_in;
   logic [15:0]               volts_ff, volts_in;
   logic signed [31:0]        speed_ff, speed_in;
   logic signed [31:0]        err_ff, err_in;
   logic signed [31:0]        deriv_ff, deriv_in;
   logic signed [31:0]        isum_ff, isum_in;     // clamped integral, model state
   logic signed [31:0]        prev_ff, prev_in;     // last error, model state
   logic                      ilim_ff, ilim_in;
   logic signed [U_W-1:0]     u_ff, u_in;
   logic                      u_neg_ff, u_neg_in;
   logic                      u_zero_ff, u_zero_in;
   logic                      over_ff, over_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]        rsp_duty_ff, rsp_duty_in;
   logic signed [31:0]        rsp_speed_ff, rsp_speed_in;
   logic                      rsp_ilim_ff, rsp_ilim_in;
   logic                      rsp_dlim_ff, rsp_dlim_in;

   logic                      accept;
   logic                      mul_start;
   logic signed [MCAND_W-1:0] mul_mcand;
   logic signed [MPLIER_W-1:0] mul_mplier;
   logic                      mul_done;
   logic signed [PROD_W-1:0]  mul_prod;

   logic                      div_start;
   logic [NUM_W-1:0]          div_num;
   div_result_type            div_res;

   logic signed [32:0]        isum_raw;
   logic [U_W-1:0]            mag;
   logic                      q_big;
   logic signed [15:0]        duty;
   logic                      dlim;

   mspid_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .gains   (gains)
   );

   mspid_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_mcand),
      .mplier  (mul_mplier),
      .done    (mul_done),
      .product (mul_prod)
   );

   mspid_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .divisor ({volts_ff, 1'b0}),
      .result  (div_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // magnitude of the control effort; beyond 2^40 the duty saturates anyway
   always_comb begin
      mag     = u_ff[U_W-1] ? U_W'(-u_ff) : U_W'(u_ff);
      div_num = NUM_W'(mag[39:0]) << (24 - FRAC_BITS);
   end

   // duty from quotient, sign and the zero-voltage case
   always_comb begin
      q_big = over_ff || div_res.big;
      dlim  = 1'b0;
      if (volts_ff == '0) begin
         dlim = 1'b1;
         if (u_zero_ff)     duty = 16'sh0000;
         else if (u_neg_ff) duty = 16'sh8000;
         else               duty = 16'sh7fff;
      end else if (u_neg_ff) begin
         if (q_big || div_res.quot > QUOT_W'(32768)) begin
            duty = 16'sh8000;
            dlim = 1'b1;
         end else begin
            duty = 16'(QUOT_W'(0) - div_res.quot);
         end
      end else begin
         if (q_big || div_res.quot > QUOT_W'(32767)) begin
            duty = 16'sh7fff;
            dlim = 1'b1;
         end else begin
            duty = div_res.quot[15:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      target_in    = target_ff;
      volts_in     = volts_ff;
      speed_in     = speed_ff;
      err_in       = err_ff;
      deriv_in     = deriv_ff;
      isum_in      = isum_ff;
      prev_in      = prev_ff;
      ilim_in      = ilim_ff;
      u_in         = u_ff;
      u_neg_in     = u_neg_ff;
      u_zero_in    = u_zero_ff;
      over_in      = over_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_duty_in  = rsp_duty_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_ilim_in  = rsp_ilim_ff;
      rsp_dlim_in  = rsp_dlim_ff;
      mul_start    = 1'b0;
      mul_mcand    = MCAND_W'(gains.prop);
      mul_mplier   = err_ff;
      div_start    = 1'b0;
      isum_raw     = 33'(isum_ff) + 33'(err_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // speed product: pulses times unsigned pulse scale
               target_in  = req_target_speed;
               volts_in   = req_battery_volts;
               mul_start  = 1'b1;
               mul_mcand  = {1'b0, gains.pulse_to_speed};
               mul_mplier = MPLIER_W'(req_pulse_count);
               op_in      = OP_SPEED;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) state_in = (op_ff == OP_SPEED) ? ST_SPEED : ST_ACCUM;
         end
         ST_SPEED: begin
            speed_in = sat32(66'sd0 - 66'(mul_prod));
            state_in = ST_ERROR;
         end
         ST_ERROR: begin
            err_in   = sat32(66'(target_ff) - 66'(speed_ff));
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            // integral clamp and derivative; state advances here
            ilim_in = 1'b0;
            if (isum_raw > LIM) begin
               isum_in = 32'(LIM);
               ilim_in = 1'b1;
            end else if (isum_raw < -LIM) begin
               isum_in = 32'(-LIM);
               ilim_in = 1'b1;
            end else begin
               isum_in = 32'(isum_raw);
            end
            deriv_in   = sat32(66'(err_ff) - 66'(prev_ff));
            prev_in    = err_ff;
            u_in       = '0;
            mul_start  = 1'b1;
            mul_mcand  = MCAND_W'(gains.prop);
            mul_mplier = err_ff;
            op_in      = OP_PROP;
            state_in   = ST_MUL;
         end
         ST_ACCUM: begin
            // product >>> FRAC_BITS rounds toward minus infinity
            u_in = u_ff + U_W'(mul_prod >>> FRAC_BITS);
            case (op_ff)
               OP_PROP: begin
                  mul_start  = 1'b1;
                  mul_mcand  = MCAND_W'(gains.integral);
                  mul_mplier = isum_ff;
                  op_in      = OP_INTEG;
                  state_in   = ST_MUL;
               end
               OP_INTEG: begin
                  mul_start  = 1'b1;
                  mul_mcand  = MCAND_W'(gains.deriv);
                  mul_mplier = deriv_ff;
                  op_in      = OP_DERIV;
                  state_in   = ST_MUL;
               end
               OP_DERIV: begin
                  mul_start  = 1'b1;
                  mul_mcand  = MCAND_W'(gains.speed_fb);
                  mul_mplier = speed_ff;
                  op_in      = OP_FEED;
                  state_in   = ST_MUL;
               end
               default: state_in = ST_SETUP;
            endcase
         end
         ST_SETUP: begin
            u_neg_in  = u_ff[U_W-1];
            u_zero_in = (u_ff == '0);
            over_in   = |mag[U_W-1:40];
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_res.done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in  = duty;
               rsp_speed_in = speed_ff;
               rsp_ilim_in  = ilim_ff;
               rsp_dlim_in  = dlim;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SPEED;
         isum_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         isum_ff      <= isum_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff    <= target_in;
      volts_ff     <= volts_in;
      speed_ff     <= speed_in;
      err_ff       <= err_in;
      deriv_ff     <= deriv_in;
      ilim_ff      <= ilim_in;
      u_ff         <= u_in;
      u_neg_ff     <= u_neg_in;
      u_zero_ff    <= u_zero_in;
      over_ff      <= over_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_ilim_ff  <= rsp_ilim_in;
      rsp_dlim_ff  <= rsp_dlim_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_duty             = rsp_duty_ff;
   assign rsp_measured_speed   = rsp_speed_ff;
   assign rsp_integral_limited = rsp_ilim_ff;
   assign rsp_duty_limited     = rsp_dlim_ff;

endmodule

`default_nettype wire

FILE: sim/tb.sv
// Self-checking bench for the motor speed PID block with supply compensation.
`timescale 1ns / 100ps

module tb;
   import mspid_pkg::*;

   // Fixed point and limits, as the block sees them at its default size
   localparam int     FRAC      = FRAC_BITS_DEF;
   localparam longint S32_MAX   = 64'sd2147483647;
   localparam longint S32_MIN   = -64'sd2147483648;
   localparam longint LIM_RAW   = longint'(150) << FRAC;
   localparam longint INTEG_LIM = (LIM_RAW > S32_MAX) ? S32_MAX : LIM_RAW;
   // Past this magnitude the duty is saturated whatever the voltage
   localparam longint U_HUGE    = longint'(1) << 40;
   localparam int     HOLD_CYCLES  = 1500;
   localparam int     ITEMS_PHASE  = 215;

   // One result item of the block
   typedef struct packed {
      logic signed [15:0] duty;
      logic signed [31:0] speed;
      logic               ilim;
      logic               dlim;
   } drive_type;

   // One row of the directed stimulus
   typedef struct {
      int                 gain_set;
      logic signed [31:0] target;
      logic signed [15:0] pulses;
      logic [15:0]        volts;
      bit                 typed;
      drive_type          want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic signed [31:0]    req_target_speed = '0;
   logic signed [15:0]    req_pulse_count  = '0;
   logic [15:0]           req_battery_volts = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [15:0]    rsp_duty;
   logic signed [31:0]    rsp_measured_speed;
   logic                  rsp_integral_limited;
   logic                  rsp_duty_limited;

   logic                  psel    = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr   = '0;
   logic [CSR_DATA_W-1:0] pwdata  = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Predictor state: gains as loaded, integral and last error
   gains_type gains;
   longint    integ_acc;
   longint    last_err;

   drive_type    drive_q[$];       // expected results, oldest first
   stim_row_type dir_rows[$];
   gains_type    gain_sets[4];

   int mismatches    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_seq      = 0;       // bumped by the stimulus to ask for a long hold
   int hold_seen     = 0;
   int hold_left     = 0;

   always #5 clock = ~clock;

   motor_speed_pid_with_supply_comp i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_target_speed     (req_target_speed),
      .req_pulse_count      (req_pulse_count),
      .req_battery_volts    (req_battery_volts),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_duty             (rsp_duty),
      .rsp_measured_speed   (rsp_measured_speed),
      .rsp_integral_limited (rsp_integral_limited),
      .rsp_duty_limited     (rsp_duty_limited),
      .psel                 (psel),
      .penable              (penable),
      .pwrite               (pwrite),
      .paddr                (paddr),
      .pwdata               (pwdata),
      .prdata               (prdata),
      .pready               (pready)
   );

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic longint sat32(longint x);
      if (x > S32_MAX) return S32_MAX;
      if (x < S32_MIN) return S32_MIN;
      return x;
   endfunction

   // One control tick: speed, error, clamped integral, PID sum, divide by
   // the supply. Updates the integral and the last error.
   function automatic drive_type pid_tick(logic signed [31:0] target,
                                          logic signed [15:0] pulses,
                                          logic [15:0] volts);
      longint speed, err, integ, deriv, u, mag, q, duty;
      drive_type r;
      r.ilim = 1'b0;
      r.dlim = 1'b0;
      speed = sat32(-(longint'(pulses) * longint'(gains.pulse_to_speed)));
      err   = sat32(longint'(target) - speed);
      integ = integ_acc + err;
      if (integ > INTEG_LIM) begin
         integ  = INTEG_LIM;
         r.ilim = 1'b1;
      end
      if (integ < -INTEG_LIM) begin
         integ  = -INTEG_LIM;
         r.ilim = 1'b1;
      end
      deriv = sat32(err - last_err);
      // each product floors on the shift; the sum is left unsaturated
      u = ((longint'($signed(gains.prop))     * err)   >>> FRAC)
        + ((longint'($signed(gains.integral)) * integ) >>> FRAC)
        + ((longint'($signed(gains.deriv))    * deriv) >>> FRAC)
        + ((longint'($signed(gains.speed_fb)) * speed) >>> FRAC);
      if (volts == 16'd0) begin
         duty   = (u > 0) ? 32767 : ((u < 0) ? -32768 : 0);
         r.dlim = 1'b1;
      end else begin
         mag = (u < 0) ? -u : u;
         if (mag >= U_HUGE) q = longint'(1) << 20;
         else q = (mag << (24 - FRAC)) / (longint'(volts) * 2);
         if (u < 0) begin
            // exactly -1.0 passes unflagged
            if (q > 32768) begin
               q      = 32768;
               r.dlim = 1'b1;
            end
            duty = -q;
         end else begin
            if (q > 32767) begin
               q      = 32767;
               r.dlim = 1'b1;
            end
            duty = q;
         end
      end
      integ_acc = integ;
      last_err  = err;
      r.duty  = duty[15:0];
      r.speed = speed[31:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Reporting and result checking
   // ------------------------------------------------------------------
   task automatic note_mismatch(string field, longint got, longint want);
      mismatches++;
      $display("ERROR %0t: %s got %0d want %0d", $time, field, got, want);
   endtask

   // Results are sampled on the edge that accepts them; rsp_stall read here
   // is the value the block sees on the same edge.
   always @(posedge clock) begin
      drive_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (drive_q.size() == 0) begin
            note_mismatch("result with nothing pending", rsp_duty, 0);
         end else begin
            want = drive_q.pop_front();
            if (rsp_duty !== want.duty)
               note_mismatch("duty", rsp_duty, want.duty);
            if (rsp_measured_speed !== want.speed)
               note_mismatch("measured_speed", rsp_measured_speed, want.speed);
            if (rsp_integral_limited !== want.ilim)
               note_mismatch("integral_limited", rsp_integral_limited, want.ilim);
            if (rsp_duty_limited !== want.dlim)
               note_mismatch("duty_limited", rsp_duty_limited, want.dlim);
         end
      end
   end

   // Receiver: random stalls, plus one long hold on request that lets the
   // block fill its output register and back up into req_stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Write one register, then read it back. Starts on a fresh edge so that
   // psel is never lowered and raised in the same step.
   task automatic csr_write(reg_index_type idx, logic [31:0] val);
      logic [31:0] rd;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd !== val) note_mismatch("register readback", rd, val);
   endtask

   task automatic load_gains(gains_type g);
      csr_write(REG_GAIN_PROP,      g.prop);
      csr_write(REG_GAIN_INTEGRAL,  g.integral);
      csr_write(REG_GAIN_DERIV,     g.deriv);
      csr_write(REG_GAIN_SPEED_FB,  g.speed_fb);
      csr_write(REG_PULSE_TO_SPEED, g.pulse_to_speed);
      gains = g;
   endtask

   // Offer one item and return on the edge that accepts it. valid stays
   // high into the next item unless a gap is drawn.
   task automatic offer_item(logic signed [31:0] tgt, logic signed [15:0] pls,
                             logic [15:0] vlt);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid         <= 1'b1;
      req_target_speed  <= tgt;
      req_pulse_count   <= pls;
      req_battery_volts <= vlt;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering and wait until every pending result is back. Every item
   // yields a result, so the block is idle once the queue is empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(int gset, logic signed [31:0] tgt, logic signed [15:0] pls,
                          logic [15:0] vlt, bit typed, logic signed [15:0] duty,
                          logic signed [31:0] spd, bit il, bit dl);
      stim_row_type r;
      r.gain_set   = gset;
      r.target     = tgt;
      r.pulses     = pls;
      r.volts      = vlt;
      r.typed      = typed;
      r.want.duty  = duty;
      r.want.speed = spd;
      r.want.ilim  = il;
      r.want.dlim  = dl;
      dir_rows.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // Random content
   // ------------------------------------------------------------------
   function automatic logic [31:0] rand_gain();
      int pick;
      logic [31:0] m;
      pick = $urandom_range(99);
      if (pick < 70) begin
         // mostly within +-1.5 so the duty lands inside its range often
         m = $urandom_range(32'h18000);
         return $urandom_range(1) ? m : -m;
      end
      if (pick < 85) return $urandom();
      case ($urandom_range(2))
         0:       return 32'h0;
         1:       return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   function automatic gains_type rand_gains();
      gains_type g;
      int pick;
      g.prop     = rand_gain();
      g.integral = rand_gain();
      g.deriv    = rand_gain();
      g.speed_fb = rand_gain();
      pick = $urandom_range(99);
      if (pick < 75)      g.pulse_to_speed = $urandom_range(32'h30000);
      else if (pick < 90) g.pulse_to_speed = $urandom();
      else                g.pulse_to_speed = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      return g;
   endfunction

   function automatic logic signed [31:0] rand_target();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return $signed($urandom_range(32'h3C_0000)) - 32'sh1E_0000;
      if (pick < 80) return $urandom();
      case ($urandom_range(2))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         default: return 32'sh0;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_pulses();
      int pick;
      logic [31:0] w;
      pick = $urandom_range(99);
      if (pick < 60) return 16'($signed($urandom_range(80)) - 40);
      w = $urandom();
      if (pick < 85) return w[15:0];
      case ($urandom_range(4))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'sh0001;
         3:       return 16'shFFFF;
         default: return 16'sh0;
      endcase
   endfunction

   function automatic logic [15:0] rand_volts();
      int pick;
      logic [31:0] w;
      pick = $urandom_range(99);
      // 6 V to 24 V is the normal band, Q8.8
      if (pick < 70) return 16'($urandom_range(16'h1800, 16'h0600));
      if (pick < 80) return 16'h0;
      w = $urandom();
      if (pick < 90) return w[15:0];
      return $urandom_range(1) ? 16'hFFFF : 16'h0001;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      drive_type got;
      int cur_set;
      logic signed [31:0] tgt;
      logic signed [15:0] pls;
      logic [15:0] vlt;

      // gain set 0 is the reset state: no write needed
      gain_sets[0] = '{prop: 32'sh0, integral: 32'sh0, deriv: 32'sh0, speed_fb: 32'sh0,
                       pulse_to_speed: 32'h0001_0000};
      // kp = 1.0 only, so the duty is error over volts
      gain_sets[1] = '{prop: 32'sh0001_0000, integral: 32'sh0, deriv: 32'sh0,
                       speed_fb: 32'sh0, pulse_to_speed: 32'h0001_0000};
      // every register at an extreme
      gain_sets[2] = '{prop: 32'sh8000_0000, integral: 32'sh7FFF_FFFF,
                       deriv: 32'sh8000_0000, speed_fb: 32'sh7FFF_FFFF,
                       pulse_to_speed: 32'hFFFF_FFFF};
      // zero pulse scale, mixed moderate gains
      gain_sets[3] = '{prop: 32'sh0002_0000, integral: 32'sh0000_8000,
                       deriv: 32'shFFFF_0000, speed_fb: 32'sh0001_0000,
                       pulse_to_speed: 32'h0};

      gains     = gain_sets[0];
      integ_acc = 0;
      last_err  = 0;

      // Reset-state rows: all gains zero, so u = 0 and only speed and the
      // flags move. Expected values typed in.
      add_row(0, 32'sh0, 16'sh0, 16'h0C00, 1, 16'sh0, 32'sh0, 0, 0);
      add_row(0, 32'sh0, 16'sh1, 16'h0C00, 1, 16'sh0, 32'shFFFF_0000, 0, 0);
      // most negative count: speed saturates high, integral clamps low
      add_row(0, 32'sh0, 16'sh8000, 16'hFFFF, 1, 16'sh0, 32'sh7FFF_FFFF, 1, 0);
      // error overflows high, integral clamps high
      add_row(0, 32'sh7FFF_FFFF, 16'sh7FFF, 16'h0C00, 1, 16'sh0, 32'sh8001_0000, 1, 0);
      // zero volts with u = 0: duty 0 but flagged
      add_row(0, 32'sh0, 16'sh0, 16'h0000, 1, 16'sh0, 32'sh0, 0, 1);
      add_row(0, 32'sh8000_0000, 16'sh0, 16'h0001, 1, 16'sh0, 32'sh0, 1, 0);
      // kp = 1.0: exactly -1.0, positive clamp, mid scale, zero-volt signs
      add_row(1, -32'sh1_0000, 16'sh0, 16'h0100, 0, 0, 0, 0, 0);
      add_row(1, 32'sh1_0000, 16'sh0, 16'h0100, 0, 0, 0, 0, 0);
      add_row(1, 32'sh8000, 16'sh0, 16'h0100, 0, 0, 0, 0, 0);
      add_row(1, 32'sh1, 16'sh0, 16'h0000, 0, 0, 0, 0, 0);
      add_row(1, -32'sh1, 16'sh0, 16'h0000, 0, 0, 0, 0, 0);
      add_row(1, 32'sh7FFF_FFFF, 16'sh7FFF, 16'hFFFF, 0, 0, 0, 0, 0);
      add_row(1, 32'sh1, 16'sh0, 16'h0001, 0, 0, 0, 0, 0);
      // small negative quotient truncates to zero
      add_row(1, -32'sh3, 16'sh0, 16'hFFFF, 0, 0, 0, 0, 0);
      // extremes: huge u, derivative overflow, zero volts
      add_row(2, 32'sh7FFF_FFFF, 16'sh1, 16'h0C00, 0, 0, 0, 0, 0);
      add_row(2, 32'sh8000_0000, -16'sh1, 16'hFFFF, 0, 0, 0, 0, 0);
      add_row(2, 32'sh0, 16'sh0, 16'h8000, 0, 0, 0, 0, 0);
      add_row(2, 32'sh0123_4567, 16'sh0, 16'h0000, 0, 0, 0, 0, 0);
      // zero pulse scale: speed stays zero for any count
      add_row(3, 32'sh64_0000, 16'sh8000, 16'h0C00, 0, 0, 0, 0, 0);
      add_row(3, -32'sh5_0000, 16'sh7FFF, 16'h0600, 0, 0, 0, 0, 0);
      add_row(3, 32'sh2_8000, 16'sh0, 16'h1800, 0, 0, 0, 0, 0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part runs with the first idling mix
      send_idle_pct = 18;
      recv_idle_pct = 86;
      cur_set = 0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].gain_set != cur_set) begin
            settle();
            cur_set = dir_rows[i].gain_set;
            load_gains(gain_sets[cur_set]);
         end
         offer_item(dir_rows[i].target, dir_rows[i].pulses, dir_rows[i].volts);
         got = pid_tick(dir_rows[i].target, dir_rows[i].pulses, dir_rows[i].volts);
         drive_q.push_back(dir_rows[i].typed ? dir_rows[i].want : got);
      end

      // Random phases, each with fresh gains. Idling: sender light and
      // receiver heavy, then swapped, then none at all.
      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph / 2)
            0: begin
               send_idle_pct = 18;
               recv_idle_pct = 86;
            end
            1: begin
               send_idle_pct = 86;
               recv_idle_pct = 18;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         load_gains(rand_gains());
         for (int n = 0; n < ITEMS_PHASE; n++) begin
            // long receiver hold while items keep coming
            if (ph == 4 && n == 40) hold_seq++;
            tgt = rand_target();
            pls = rand_pulses();
            vlt = rand_volts();
            offer_item(tgt, pls, vlt);
            drive_q.push_back(pid_tick(tgt, pls, vlt));
         end
      end

      settle();
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("motor_speed_pid_with_supply_comp: match");
      end else begin
         $display("motor_speed_pid_with_supply_comp: mismatch");
      end
      $finish;
   end

   // Watchdog: several times the longest expected run
   initial begin
      #8_000_000;
      $display("motor_speed_pid_with_supply_comp: mismatch");
      $finish;
   end

endmodule
